// ===== sv/ptlm_pkg.sv =====
// Shared types, codes and the prefix mask function of the prefix table
`default_nettype none
package ptlm_pkg;

	localparam int ADDR_W     = 64;
	localparam int LEN_W      = 8;
	localparam int VAL_W      = 32;
	localparam int V4_LEN_MAX = 32;
	localparam int V6_LEN_MAX = 128;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic              is_v6;
		logic [ADDR_W-1:0] addr_high;
		logic [ADDR_W-1:0] addr_low;
		logic [LEN_W-1:0]  prefix_len;
		logic [VAL_W-1:0]  route_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [ADDR_W-1:0] match_high;
		logic [ADDR_W-1:0] match_low;
		logic [LEN_W-1:0]  match_len;
		logic              match_is_v6;
		logic [VAL_W-1:0]  match_value;
	} out_item_t;

	typedef struct packed {
		logic              valid;
		logic              is_v6;
		logic [ADDR_W-1:0] addr_high;
		logic [ADDR_W-1:0] addr_low;
		logic [LEN_W-1:0]  len;
		logic [VAL_W-1:0]  value;
	} entry_t;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic cnt_inc;
		logic clear_wr;
		logic rd_en;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic in_skip;
		logic out_free;
	} sts_t;

	function automatic logic [2*ADDR_W-1:0] prefix_mask(input logic v6,
			input logic [LEN_W-1:0] len);
		logic [2*ADDR_W-1:0] m;
		if (v6) begin
			m = ~({(2*ADDR_W){1'b1}} >> len);
		end else begin
			m = {{(2*ADDR_W-V4_LEN_MAX){1'b0}}, ~({V4_LEN_MAX{1'b1}} >> len)};
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== sv/ptlm_ctrl.sv =====
// Sequencer of the prefix table: clearing pass, scan, commit and result hand-off
`default_nettype none
module ptlm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output logic               op_stall,
	input  wire ptlm_pkg::sts_t sts,
	output ptlm_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (op_valid) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = sts.in_skip ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign op_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register occupied");

	a_no_load_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !cmd.load && !cmd.commit && !cmd.rd_en)
		else $error("transfer or table access during clearing pass");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.cnt_last) |=> state_q == ST_DRAIN)
		else $error("scan did not end after last entry");

	a_commit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(state_q) == ST_DRAIN)
		else $error("commit without completed scan");

endmodule
`default_nettype wire

// ===== sv/ptlm_dp.sv =====
// Datapath of the prefix table: entry memory, scan counter, match tracking, result register
`default_nettype none
module ptlm_dp #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ptlm_pkg::in_item_t op,
	output ptlm_pkg::out_item_t     res,
	output logic                    res_valid,
	input  wire logic               res_stall,
	input  wire ptlm_pkg::cmd_t     cmd,
	output ptlm_pkg::sts_t          sts
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int QW = 2 * ptlm_pkg::ADDR_W;

	ptlm_pkg::entry_t table_q [TABLE_DEPTH];
	ptlm_pkg::entry_t rdata_s1;
	logic             rdv_s1;
	logic [AW-1:0]    ridx_s1;
	logic [AW-1:0]    cnt_q;

	logic [1:0]                  kind_q;
	logic                        v6_q;
	logic [QW-1:0]               qa_q;
	logic [QW-1:0]               key_q;
	logic [ptlm_pkg::LEN_W-1:0]  len_q;
	logic [ptlm_pkg::VAL_W-1:0]  val_q;
	logic                        bad_q;

	logic             hit_v_q;
	logic [AW-1:0]    hit_idx_q;
	logic             free_v_q;
	logic [AW-1:0]    free_idx_q;
	logic             best_v_q;
	ptlm_pkg::entry_t best_q;

	logic                out_valid_q;
	ptlm_pkg::out_item_t res_q;
	ptlm_pkg::out_item_t res_d;

	logic [QW-1:0]    in_addr;
	logic             in_bad;
	logic [QW-1:0]    e_addr;
	logic             fam_ok;
	logic             key_hit;
	logic             pm_hit;
	logic             better;
	logic             we;
	logic [AW-1:0]    waddr;
	ptlm_pkg::entry_t wdata;

	assign in_addr = op.is_v6 ? {op.addr_high, op.addr_low}
		: {{(QW-ptlm_pkg::V4_LEN_MAX){1'b0}}, op.addr_low[ptlm_pkg::V4_LEN_MAX-1:0]};
	assign in_bad = op.prefix_len > (op.is_v6 ? ptlm_pkg::LEN_W'(ptlm_pkg::V6_LEN_MAX)
		: ptlm_pkg::LEN_W'(ptlm_pkg::V4_LEN_MAX));

	assign sts.in_skip  = in_bad || (op.kind == ptlm_pkg::KIND_NONE);
	assign sts.cnt_last = (cnt_q == AW'(TABLE_DEPTH - 1));
	assign sts.out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= op.kind;
			v6_q   <= op.is_v6;
			qa_q   <= in_addr;
			key_q  <= in_addr & ptlm_pkg::prefix_mask(op.is_v6, op.prefix_len);
			len_q  <= op.prefix_len;
			val_q  <= op.route_value;
			bad_q  <= in_bad;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = '0;
		if (cmd.clear_wr) begin
			we = 1'b1;
		end else if (cmd.commit) begin
			waddr           = hit_v_q ? hit_idx_q : free_idx_q;
			wdata.valid     = (kind_q == ptlm_pkg::KIND_INSERT);
			wdata.is_v6     = v6_q;
			wdata.addr_high = key_q[QW-1:ptlm_pkg::ADDR_W];
			wdata.addr_low  = key_q[ptlm_pkg::ADDR_W-1:0];
			wdata.len       = len_q;
			wdata.value     = val_q;
			we = ((kind_q == ptlm_pkg::KIND_INSERT) && (hit_v_q || free_v_q))
				|| ((kind_q == ptlm_pkg::KIND_DELETE) && hit_v_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= table_q[cnt_q];
			ridx_s1  <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.rd_en;
		end
	end

	assign e_addr  = {rdata_s1.addr_high, rdata_s1.addr_low};
	assign fam_ok  = rdata_s1.valid && (rdata_s1.is_v6 == v6_q);
	assign key_hit = fam_ok && (rdata_s1.len == len_q) && (e_addr == key_q);
	assign pm_hit  = fam_ok && (rdata_s1.len <= len_q)
		&& (((qa_q ^ e_addr) & ptlm_pkg::prefix_mask(v6_q, rdata_s1.len)) == '0);
	assign better  = !best_v_q || (rdata_s1.len > best_q.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
		end else if (cmd.load) begin
			hit_v_q  <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
		end else if (rdv_s1) begin
			if (key_hit && !hit_v_q) begin
				hit_v_q <= 1'b1;
			end
			if (!rdata_s1.valid && !free_v_q) begin
				free_v_q <= 1'b1;
			end
			if (pm_hit && better) begin
				best_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			if (key_hit && !hit_v_q) begin
				hit_idx_q <= ridx_s1;
			end
			if (!rdata_s1.valid && !free_v_q) begin
				free_idx_q <= ridx_s1;
			end
			if (pm_hit && better) begin
				best_q <= rdata_s1;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (bad_q && (kind_q != ptlm_pkg::KIND_NONE)) begin
			res_d.status = ptlm_pkg::STATUS_INVALID;
		end else begin
			case (kind_q)
				ptlm_pkg::KIND_INSERT: begin
					if (!hit_v_q && !free_v_q) begin
						res_d.status = ptlm_pkg::STATUS_FULL;
					end
				end
				ptlm_pkg::KIND_DELETE: begin
					res_d.found = hit_v_q;
				end
				ptlm_pkg::KIND_LOOKUP: begin
					if (best_v_q) begin
						res_d.found       = 1'b1;
						res_d.match_high  = best_q.addr_high;
						res_d.match_low   = best_q.addr_low;
						res_d.match_len   = best_q.len;
						res_d.match_is_v6 = best_q.is_v6;
						res_d.match_value = best_q.value;
					end
				end
				default: begin
					res_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== sv/prefix_table_longest_match.sv =====
// Top level of the longest-prefix-match route table
//
//   channel  dir  handshake            payload
//   op       in   op_valid/op_stall    ptlm_pkg::in_item_t
//   res      out  res_valid/res_stall  ptlm_pkg::out_item_t
//
// Lookup, insert and delete each scan every entry once through the entry memory,
// one entry a cycle, then pass the drain and commit states before the result loads.
// A kind of no operation or an out-of-range length skips the scan and the commit.
// After reset a clearing pass writes every entry empty; op_stall stays high.
// A result waiting under res_stall holds; the next op is taken meanwhile.
`default_nettype none
module prefix_table_longest_match #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               op_valid,
	output logic                    op_stall,
	input  wire ptlm_pkg::in_item_t op,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output ptlm_pkg::out_item_t     res
);

	ptlm_pkg::cmd_t cmd;
	ptlm_pkg::sts_t sts;

	ptlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptlm_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

// ===== tb/sv/prefix_table_longest_match_test.sv =====
// Self-checking testbench for the longest-prefix-match route table
`default_nettype none
module prefix_table_longest_match_test;
	import ptlm_pkg::*;

	localparam int DEPTH          = 256;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 300;
	localparam int RANDOM_OPS     = 740;
	localparam int POOL_MAX       = 48;
	localparam int PRINT_MAX      = 100;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      op_valid;
	logic      op_stall;
	in_item_t  op;
	logic      res_valid;
	logic      res_stall;
	out_item_t res;

	logic         tbl_valid [DEPTH];
	logic         tbl_v6    [DEPTH];
	logic [127:0] tbl_addr  [DEPTH];
	logic [7:0]   tbl_len   [DEPTH];
	logic [31:0]  tbl_value [DEPTH];

	out_item_t   pending_results [$];
	in_item_t    route_pool [$];
	int unsigned n_sent;
	int unsigned n_results = 0;
	int unsigned n_errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left;
	int unsigned stall_phase_left;
	int unsigned stall_style;

	prefix_table_longest_match #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.op(op),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #4 clk = ~clk;

	function automatic logic [127:0] prefix_bits(input logic v6, input int unsigned len);
		logic [127:0] ones;
		ones = '1;
		if (len == 0)
			return '0;
		if (v6)
			return ones << (128 - len);
		return (ones << (32 - len)) & {96'h0, 32'hFFFF_FFFF};
	endfunction

	function automatic out_item_t route_result(input in_item_t item);
		out_item_t    r;
		logic [127:0] addr;
		logic [127:0] key;
		int unsigned  width;
		int unsigned  len;
		int           slot;
		int           best;
		int           i;
		r = '0;
		width = item.is_v6 ? V6_LEN_MAX : V4_LEN_MAX;
		len = 32'(item.prefix_len);
		addr = item.is_v6 ? {item.addr_high, item.addr_low} : {96'h0, item.addr_low[31:0]};
		if (item.kind == KIND_NONE)
			return r;
		if (len > width) begin
			r.status = STATUS_INVALID;
			return r;
		end
		key = addr & prefix_bits(item.is_v6, len);
		slot = -1;
		for (i = 0; i < DEPTH; i++) begin
			if (slot < 0 && tbl_valid[i] && tbl_v6[i] == item.is_v6 && tbl_len[i] == len
					&& tbl_addr[i] == key)
				slot = i;
		end
		case (item.kind)
			KIND_INSERT: begin
				if (slot < 0) begin
					for (i = DEPTH - 1; i >= 0; i--) begin
						if (!tbl_valid[i])
							slot = i;
					end
					if (slot < 0) begin
						r.status = STATUS_FULL;
						return r;
					end
					tbl_valid[slot] = 1'b1;
					tbl_v6[slot] = item.is_v6;
					tbl_addr[slot] = key;
					tbl_len[slot] = 8'(len);
				end
				tbl_value[slot] = item.route_value;
			end
			KIND_DELETE: begin
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b0;
					r.found = 1'b1;
				end
			end
			KIND_LOOKUP: begin
				best = -1;
				for (i = 0; i < DEPTH; i++) begin
					if (tbl_valid[i] && tbl_v6[i] == item.is_v6 && tbl_len[i] <= len
							&& (best < 0 || tbl_len[i] > tbl_len[best])
							&& (addr & prefix_bits(item.is_v6, tbl_len[i])) == tbl_addr[i])
						best = i;
				end
				if (best >= 0) begin
					r.found = 1'b1;
					r.match_high = tbl_addr[best][127:64];
					r.match_low = tbl_addr[best][63:0];
					r.match_len = tbl_len[best];
					r.match_is_v6 = tbl_v6[best];
					r.match_value = tbl_value[best];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic in_item_t make_op(input logic [1:0] kind, input logic v6,
			input logic [63:0] hi, input logic [63:0] lo, input logic [7:0] len,
			input logic [31:0] val);
		in_item_t item;
		item.kind = kind;
		item.is_v6 = v6;
		item.addr_high = hi;
		item.addr_low = lo;
		item.prefix_len = len;
		item.route_value = val;
		return item;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= PRINT_MAX)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				n_results, name, got, want));
	endtask

	// compare on each result transfer, then predict on each op transfer
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing pending", n_results));
				end else begin
					want = pending_results.pop_front();
					check_field("status", res.status, want.status);
					check_field("found", res.found, want.found);
					check_field("match_high", res.match_high, want.match_high);
					check_field("match_low", res.match_low, want.match_low);
					check_field("match_len", res.match_len, want.match_len);
					check_field("match_is_v6", res.match_is_v6, want.match_is_v6);
					check_field("match_value", res.match_value, want.match_value);
				end
				n_results++;
			end
			if (op_valid && !op_stall)
				pending_results.push_back(route_result(op));
		end else begin
			foreach (tbl_valid[i])
				tbl_valid[i] = 1'b0;
		end
		if ((op_valid && !op_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_phase_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_phase_left = $urandom_range(200, 2000);
		end else begin
			stall_phase_left--;
		end
		case (stall_style)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 1) == 1);
			default: res_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	task automatic pause_sender();
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
		@(negedge clk);
		op_valid <= 1'b0;
		repeat (gap - 1) @(negedge clk);
		burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
	endtask

	task automatic send_op(input in_item_t item);
		@(negedge clk);
		op <= item;
		op_valid <= 1'b1;
		do @(posedge clk); while (op_stall);
		n_sent++;
		if (burst_left > 0)
			burst_left--;
		else
			pause_sender();
	endtask

	// hold off until every transfer in flight has its result
	task automatic drain_results();
		@(negedge clk);
		op_valid <= 1'b0;
		wait (n_results >= n_sent);
	endtask

	task automatic test_directed();
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A01_0203, 8'd32, 32'h0));
		send_op(make_op(KIND_INSERT, 1'b0, 64'hDEAD_BEEF_0000_0001, 64'hFFFF_0000_1234_5678,
			8'd0, 32'h0000_00A0));
		send_op(make_op(KIND_INSERT, 1'b0, 64'h0, 64'hFFFF_FFFF_0A0B_0C0D, 8'd8, 32'h0000_00B0));
		send_op(make_op(KIND_INSERT, 1'b0, 64'h0, 64'h0000_0000_FFFF_FFFF, 8'd32, 32'hFFFF_FFFF));
		send_op(make_op(KIND_INSERT, 1'b1, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
			8'd0, 32'h0000_00D0));
		send_op(make_op(KIND_INSERT, 1'b1, '1, '1, 8'd128, 32'h0000_00E0));
		send_op(make_op(KIND_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 64'h5555_AAAA_5555_AAAA,
			8'd64, 32'h0000_00F0));
		send_op(make_op(KIND_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000,
			8'd65, 32'h0000_0100));
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A0B_0C0D, 8'd32, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A0B_0C0D, 8'd7, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b0, '1, '1, 8'd32, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b1, '1, '1, 8'd128, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, '1, 8'd128, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			8'd128, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0, 8'd64, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'h0, 64'h0, 8'd0, 32'h0));
		send_op(make_op(KIND_INSERT, 1'b0, 64'h0, 64'h0A00_0000, 8'd8, 32'h0000_0B0B));
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A00_0001, 8'd32, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A00_0001, 8'd33, 32'h0));
		send_op(make_op(KIND_INSERT, 1'b1, '1, '1, 8'd129, 32'h1111_1111));
		send_op(make_op(KIND_DELETE, 1'b0, 64'h0, 64'h0A00_0000, 8'd255, 32'h0));
		send_op(make_op(KIND_NONE, 1'b1, '1, '1, 8'd128, 32'hFFFF_FFFF));
		send_op(make_op(KIND_NONE, 1'b0, '1, '1, 8'd200, 32'hFFFF_FFFF));
		send_op(make_op(KIND_DELETE, 1'b0, 64'h0, 64'h0A7F_0000, 8'd8, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b0, 64'h0, 64'h0A7F_0000, 8'd8, 32'h0));
		send_op(make_op(KIND_LOOKUP, 1'b0, 64'h0, 64'h0A00_0001, 8'd32, 32'h0));
	endtask

	task automatic test_table_full();
		int unsigned i;
		for (i = 0; i < 260; i++)
			send_op(make_op(KIND_INSERT, 1'b1, 64'hFEED_0000_0000_0000, 64'(i), 8'd128,
				$urandom));
		send_op(make_op(KIND_INSERT, 1'b1, 64'hFEED_0000_0000_0000, 64'd3, 8'd128, 32'h3333));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'hFEED_0000_0000_0000, 64'd3, 8'd128, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'hFEED_0000_0000_0000, 64'd7, 8'd128, 32'h0));
		send_op(make_op(KIND_INSERT, 1'b1, 64'hFEED_0000_0000_0000, 64'd1000, 8'd128, 32'h1000));
		send_op(make_op(KIND_INSERT, 1'b1, 64'hFEED_0000_0000_0000, 64'd1001, 8'd128, 32'h1001));
		send_op(make_op(KIND_LOOKUP, 1'b1, 64'hFEED_0000_0000_0000, 64'd1000, 8'd128, 32'h0));
		drain_results();
		for (i = 0; i < 260; i++)
			send_op(make_op(KIND_DELETE, 1'b1, 64'hFEED_0000_0000_0000, 64'(i), 8'd128, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'hFEED_0000_0000_0000, 64'd1000, 8'd128, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'hFEED_0000_0000_0000, 64'd1001, 8'd128, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b0, 64'h0, 64'h0, 8'd0, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b0, 64'h0, 64'hFFFF_FFFF, 8'd32, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'h0, 64'h0, 8'd0, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, '1, '1, 8'd128, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0, 8'd64, 32'h0));
		send_op(make_op(KIND_DELETE, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000,
			8'd65, 32'h0));
	endtask

	task automatic test_random_traffic(input int unsigned count);
		in_item_t     item;
		in_item_t     base;
		logic [127:0] m;
		logic [127:0] addr;
		int unsigned  n;
		int unsigned  pick;
		int unsigned  idx;
		int unsigned  width;
		for (n = 0; n < count; n++) begin
			if (n == count / 2)
				drain_results();
			item = make_op(KIND_LOOKUP, 1'($urandom_range(0, 1)), rand64(), rand64(), 8'd0,
				$urandom);
			width = item.is_v6 ? V6_LEN_MAX : V4_LEN_MAX;
			item.prefix_len = 8'($urandom_range(0, width));
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				item.kind = 2'($urandom_range(0, 3));
				item.prefix_len = 8'($urandom_range(0, 255));
			end else if (pick < 48) begin
				if (route_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
					base = route_pool[$urandom_range(0, route_pool.size() - 1)];
					width = base.is_v6 ? V6_LEN_MAX : V4_LEN_MAX;
					m = prefix_bits(base.is_v6, base.prefix_len);
					addr = ({base.addr_high, base.addr_low} & m)
						| ({item.addr_high, item.addr_low} & ~m);
					item.is_v6 = base.is_v6;
					{item.addr_high, item.addr_low} = addr;
					item.prefix_len = 8'($urandom_range(base.prefix_len, width));
				end
			end else if (pick < 78) begin
				item.kind = KIND_INSERT;
				if (route_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
					base = route_pool[$urandom_range(0, route_pool.size() - 1)];
					width = base.is_v6 ? V6_LEN_MAX : V4_LEN_MAX;
					item.is_v6 = base.is_v6;
					item.addr_high = base.addr_high;
					item.addr_low = base.addr_low;
					item.prefix_len = $urandom_range(0, 1) ? base.prefix_len
						: 8'($urandom_range(0, width));
				end
				route_pool.push_back(item);
				if (route_pool.size() > POOL_MAX)
					void'(route_pool.pop_front());
			end else begin
				item.kind = KIND_DELETE;
				if (route_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
					idx = $urandom_range(0, route_pool.size() - 1);
					base = route_pool[idx];
					item.is_v6 = base.is_v6;
					item.addr_high = base.addr_high;
					item.addr_low = base.addr_low;
					item.prefix_len = base.prefix_len;
					route_pool.delete(idx);
				end
			end
			send_op(item);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		op_valid = 1'b0;
		op = '0;
		n_sent = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		drain_results();
		test_table_full();
		drain_results();
		test_random_traffic(RANDOM_OPS);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
